FILE: sv/lphs_pkg.sv
// Shared constants and types for the linear-probe hash set.
package lphs_pkg;

  // Table geometry.
  localparam int unsigned TABLE_DEPTH = 256;
  localparam int unsigned SLOT_W      = $clog2(TABLE_DEPTH);
  localparam int unsigned CAP_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned KEY_W       = 31;
  localparam int unsigned KCNT_W      = $clog2(KEY_W);

  // Configuration reset value: the whole table in use.
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(TABLE_DEPTH);

  // Operation codes.
  localparam logic OP_INSERT = 1'b0;
  localparam logic OP_SEARCH = 1'b1;

  // Result status codes.
  localparam logic [2:0] ST_INSERTED = 3'd0;
  localparam logic [2:0] ST_PRESENT  = 3'd1;
  localparam logic [2:0] ST_FULL     = 3'd2;
  localparam logic [2:0] ST_FOUND    = 3'd3;
  localparam logic [2:0] ST_MISSING  = 3'd4;

  // Access request from the probe controller to the slot table.
  typedef struct packed {
    logic              rd;
    logic              wr;
    logic [SLOT_W-1:0] addr;
    logic [KEY_W-1:0]  key;
  } tbl_req_t;

endpackage

FILE: sv/linear_probe_hash_set.sv
// Linear-probe hash set: probe controller, output register and configuration.
//
// Input channel (in_valid_i / in_stall_o) carries one beat per operation: an
// opcode (insert or search) and a 31-bit key. Output channel (out_valid_o /
// out_stall_i) returns one beat per operation with a status and a slot index.
// A beat moves at a clock edge where valid is high and stall is low.
// The configuration channel (cfg_valid_i / cfg_ready_o) writes slots_in_use,
// the table capacity; it is always ready and must be written only while idle.
// Zero acts as one and values above 256 act as 256.
// After the accepting edge an operation runs the bit-serial key modulo, takes
// the remainder, probes up to capacity slots (each a memory read, then compare
// and write-back) and loads the output register.
// One operation is in flight at a time; the next can be accepted in the cycle
// after the previous result enters the output register, even if it is still
// stalled. A stalled result holds in the output register; a finished operation
// waits in the done state until the register frees.
// Reset clears all occupancy flags at once and sets the capacity to 256.
module linear_probe_hash_set
  import lphs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic             opcode_i,
  input  logic [KEY_W-1:0] key_value_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [2:0]       status_o,
  output logic [7:0]       slot_index_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [8:0]       cfg_data_i
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_HASH  = 5'b00010,
    S_READ  = 5'b00100,
    S_CHECK = 5'b01000,
    S_DONE  = 5'b10000
  } state_e;

  state_e            state_q, state_d;
  logic [8:0]        cfg_q;
  logic [CAP_W-1:0]  cap_now;
  logic              op_q, op_d;
  logic [KEY_W-1:0]  key_q, key_d;
  logic [CAP_W-1:0]  cap_q, cap_d;
  logic [SLOT_W-1:0] idx_q, idx_d;
  logic [CAP_W-1:0]  pcnt_q, pcnt_d;
  logic [2:0]        res_st_q, res_st_d;
  logic [SLOT_W-1:0] res_idx_q, res_idx_d;
  logic              out_valid_q, out_valid_d;
  logic [2:0]        out_st_q, out_st_d;
  logic [SLOT_W-1:0] out_idx_q, out_idx_d;
  logic              accept;
  logic              out_free;
  logic              hash_start;
  logic              hash_done;
  logic [SLOT_W-1:0] hash_rem;
  tbl_req_t          tbl_req;
  logic [KEY_W-1:0]  rd_key;
  logic              rd_occ;
  logic [CAP_W-1:0]  idx_inc;
  logic [CAP_W-1:0]  pcnt_inc;

  // Configuration register, always ready.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= 9'(CAP_RESET);
    end else if (cfg_valid_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  // Clamp the configured capacity into 1..TABLE_DEPTH.
  always_comb begin
    if (cfg_q == '0) begin
      cap_now = CAP_W'(1);
    end else if (CAP_W'(cfg_q) > CAP_W'(TABLE_DEPTH) || 9'(CAP_W'(cfg_q)) != cfg_q) begin
      cap_now = CAP_W'(TABLE_DEPTH);
    end else begin
      cap_now = CAP_W'(cfg_q);
    end
  end

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign hash_start = accept;
  assign idx_inc    = CAP_W'({1'b0, idx_q}) + CAP_W'(1);
  assign pcnt_inc   = pcnt_q + CAP_W'(1);

  lphs_mod u_mod (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (hash_start),
    .dividend_i (key_value_i),
    .divisor_i  (cap_now),
    .done_o     (hash_done),
    .rem_o      (hash_rem)
  );

  lphs_table u_table (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .req_i    (tbl_req),
    .rd_key_o (rd_key),
    .rd_occ_o (rd_occ)
  );

  // Probe sequencer: hash, then read and check one slot at a time.
  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    key_d       = key_q;
    cap_d       = cap_q;
    idx_d       = idx_q;
    pcnt_d      = pcnt_q;
    res_st_d    = res_st_q;
    res_idx_d   = res_idx_q;
    tbl_req     = '0;
    tbl_req.addr = idx_q;
    tbl_req.key  = key_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          op_d    = opcode_i;
          key_d   = key_value_i;
          cap_d   = cap_now;
          state_d = S_HASH;
        end
      end
      S_HASH: begin
        if (hash_done) begin
          idx_d   = hash_rem;
          pcnt_d  = '0;
          state_d = S_READ;
        end
      end
      S_READ: begin
        tbl_req.rd = 1'b1;
        state_d    = S_CHECK;
      end
      S_CHECK: begin
        if (!rd_occ) begin
          // Empty slot ends the walk; an insert claims it.
          if (op_q == OP_INSERT) begin
            tbl_req.wr = 1'b1;
            res_st_d   = ST_INSERTED;
            res_idx_d  = idx_q;
          end else begin
            res_st_d  = ST_MISSING;
            res_idx_d = '0;
          end
          state_d = S_DONE;
        end else if (rd_key == key_q) begin
          res_st_d  = (op_q == OP_INSERT) ? ST_PRESENT : ST_FOUND;
          res_idx_d = idx_q;
          state_d   = S_DONE;
        end else if (pcnt_inc == cap_q) begin
          // Every slot in use visited without a hit or a hole.
          res_st_d  = (op_q == OP_INSERT) ? ST_FULL : ST_MISSING;
          res_idx_d = '0;
          state_d   = S_DONE;
        end else begin
          idx_d   = (idx_inc == cap_q) ? '0 : idx_inc[SLOT_W-1:0];
          pcnt_d  = pcnt_inc;
          state_d = S_READ;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Output register: loaded from a finished operation, drained by the receiver.
  always_comb begin
    out_valid_d = out_valid_q;
    out_st_d    = out_st_q;
    out_idx_d   = out_idx_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (state_q == S_DONE && out_free) begin
      out_valid_d = 1'b1;
      out_st_d    = res_st_q;
      out_idx_d   = res_idx_q;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      pcnt_q      <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      pcnt_q      <= pcnt_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    op_q      <= op_d;
    key_q     <= key_d;
    cap_q     <= cap_d;
    idx_q     <= idx_d;
    res_st_q  <= res_st_d;
    res_idx_q <= res_idx_d;
    out_st_q  <= out_st_d;
    out_idx_q <= out_idx_d;
  end

  assign out_valid_o  = out_valid_q;
  assign status_o     = out_st_q;
  assign slot_index_o = 8'(out_idx_q);

`ifndef SYNTH
  // The modulo unit only finishes while the controller waits for it.
  a_hash_done_in_hash: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hash_done |-> state_q == S_HASH)
    else $error("modulo result outside hash state");

  // Slot compare always follows a read in the previous cycle.
  a_check_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CHECK |-> $past(state_q) == S_READ)
    else $error("slot check without preceding read");

  // The probe walk never exceeds the capacity in use.
  a_probe_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_CHECK |-> pcnt_q < cap_q && CAP_W'({1'b0, idx_q}) < cap_q)
    else $error("probe beyond capacity");

  // Misses and full-table results carry slot zero.
  a_miss_slot_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o == ST_FULL || status_o == ST_MISSING) |-> slot_index_o == '0)
    else $error("nonzero slot on miss or full");

  // A table write happens only for an insert into an empty slot.
  a_write_on_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tbl_req.wr |-> state_q == S_CHECK && op_q == OP_INSERT && !rd_occ)
    else $error("unexpected table write");
`endif

endmodule

FILE: sv/lphs_mod.sv
// Bit-serial restoring unit that reduces a key modulo the capacity in use.
module lphs_mod
  import lphs_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [KEY_W-1:0]  dividend_i,
  input  logic [CAP_W-1:0]  divisor_i,
  output logic              done_o,
  output logic [SLOT_W-1:0] rem_o
);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [KCNT_W-1:0] cnt_q, cnt_d;
  logic [KEY_W-1:0]  dvd_q, dvd_d;
  logic [CAP_W-1:0]  dvs_q, dvs_d;
  logic [CAP_W-1:0]  rem_q, rem_d;
  logic [CAP_W:0]    trial;

  // One quotient bit per cycle: shift in the next dividend bit, subtract if it fits.
  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    dvd_d  = dvd_q;
    dvs_d  = dvs_q;
    rem_d  = rem_q;
    trial  = {rem_q, dvd_q[KEY_W-1]};
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      dvd_d  = dividend_i;
      dvs_d  = divisor_i;
      rem_d  = '0;
    end else if (busy_q) begin
      if (trial >= {1'b0, dvs_q}) begin
        rem_d = CAP_W'(trial - {1'b0, dvs_q});
      end else begin
        rem_d = trial[CAP_W-1:0];
      end
      dvd_d = {dvd_q[KEY_W-2:0], 1'b0};
      cnt_d = cnt_q + KCNT_W'(1);
      if (cnt_q == KCNT_W'(KEY_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    dvd_q <= dvd_d;
    dvs_q <= dvs_d;
    rem_q <= rem_d;
  end

  // The remainder is below the capacity, so it fits a slot index.
  assign done_o = done_q;
  assign rem_o  = rem_q[SLOT_W-1:0];

endmodule

FILE: sv/lphs_table.sv
// Slot table: key memory with registered read, plus occupancy flags.
module lphs_table
  import lphs_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  tbl_req_t         req_i,
  output logic [KEY_W-1:0] rd_key_o,
  output logic             rd_occ_o
);

  logic [KEY_W-1:0]       key_mem [TABLE_DEPTH];
  logic [TABLE_DEPTH-1:0] occ_q;
  logic [KEY_W-1:0]       rd_key_q;
  logic                   rd_occ_q;

  // Key store: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (req_i.wr) begin
      key_mem[req_i.addr] <= req_i.key;
    end
    if (req_i.rd) begin
      rd_key_q <= key_mem[req_i.addr];
    end
  end

  // Occupancy flags are cleared at reset and read alongside the key.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q    <= '0;
      rd_occ_q <= 1'b0;
    end else begin
      if (req_i.wr) begin
        occ_q[req_i.addr] <= 1'b1;
      end
      if (req_i.rd) begin
        rd_occ_q <= occ_q[req_i.addr];
      end
    end
  end

  assign rd_key_o = rd_key_q;
  assign rd_occ_o = rd_occ_q;

endmodule

FILE: tb/sv/tb_linear_probe_hash_set.sv
// Self-checking testbench for the linear-probe hash set, with a predictor.
`timescale 1ns / 100ps

module tb_linear_probe_hash_set;
  import lphs_pkg::*;

  localparam int unsigned HALF_PERIOD   = 6;
  localparam int unsigned RESET_CYCLES  = 5;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned DRAIN_CYCLES  = 600;
  localparam int unsigned RANDOM_PER_CAP = 61;
  localparam int unsigned NUM_CAPS      = 12;
  localparam int unsigned HOLD_PHASE    = 6;
  localparam int unsigned RECENT_DEPTH  = 64;

  // Kinds of rows in the directed table.
  typedef enum logic {ROW_OP, ROW_CFG} row_kind_e;

  // How a probe walk ended.
  typedef enum logic [1:0] {PROBE_EMPTY, PROBE_HIT, PROBE_WRAPPED} probe_end_e;

  // Receiver stall patterns.
  typedef enum logic [1:0] {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_TOGGLE} stall_mode_e;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] slot;
  } hash_result_t;

  typedef struct packed {
    row_kind_e        kind;
    logic             op;
    logic [KEY_W-1:0] key;
    logic [8:0]       cap;
    logic             typed;
    logic [2:0]       status;
    logic [7:0]       slot;
  } dir_row_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_stall_o;
  logic             opcode_i    = OP_INSERT;
  logic [KEY_W-1:0] key_value_i = '0;
  logic             out_valid_o;
  logic             out_stall_i = 1'b0;
  logic [2:0]       status_o;
  logic [7:0]       slot_index_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [8:0]       cfg_data_i  = '0;

  // Shadow copy of the table and the capacity register.
  logic [KEY_W-1:0] shadow_key [TABLE_DEPTH];
  bit               shadow_used [TABLE_DEPTH];
  logic [8:0]       shadow_cap = 9'(CAP_RESET);

  hash_result_t     pending_results [$];
  hash_result_t     head_result;
  logic [KEY_W-1:0] recent_keys [$];

  int unsigned error_count = 0;
  int unsigned ops_sent    = 0;
  int unsigned cfg_writes  = 0;
  int unsigned burst_left  = 0;
  int unsigned status_seen [5];
  bit          hold_request = 1'b0;

  // Capacity values walked by the random part, extremes and out-of-range values included.
  logic [8:0] random_caps [NUM_CAPS] = '{9'd3, 9'd16, 9'd0, 9'd64, 9'd300, 9'd5,
                                         9'd256, 9'd128, 9'd2, 9'd255, 9'd511, 9'd37};

  // Directed rows: empty table, wraparound, duplicates, full table, odd capacities.
  dir_row_t directed_rows [25] = '{
    '{ROW_OP,  OP_SEARCH, 31'd0,          9'd0,   1'b1, ST_MISSING,  8'd0},
    '{ROW_OP,  OP_INSERT, 31'd0,          9'd0,   1'b1, ST_INSERTED, 8'd0},
    '{ROW_OP,  OP_INSERT, 31'd0,          9'd0,   1'b1, ST_PRESENT,  8'd0},
    '{ROW_OP,  OP_SEARCH, 31'd0,          9'd0,   1'b1, ST_FOUND,    8'd0},
    '{ROW_OP,  OP_INSERT, 31'h7FFF_FFFF,  9'd0,   1'b1, ST_INSERTED, 8'd255},
    '{ROW_OP,  OP_INSERT, 31'd256,        9'd0,   1'b1, ST_INSERTED, 8'd1},
    '{ROW_OP,  OP_INSERT, 31'd511,        9'd0,   1'b0, ST_INSERTED, 8'd0},
    '{ROW_OP,  OP_SEARCH, 31'd512,        9'd0,   1'b0, ST_INSERTED, 8'd0},
    '{ROW_OP,  OP_SEARCH, 31'd511,        9'd0,   1'b0, ST_INSERTED, 8'd0},
    '{ROW_OP,  OP_INSERT, 31'h5555_5555,  9'd0,   1'b0, ST_INSERTED, 8'd0},
    '{ROW_OP,  OP_INSERT, 31'h2AAA_AAAA,  9'd0,   1'b0, ST_INSERTED, 8'd0},
    '{ROW_OP,  OP_SEARCH, 31'h7FFF_FFFF,  9'd0,   1'b1, ST_FOUND,    8'd255},
    '{ROW_CFG, OP_INSERT, 31'd0,          9'd1,   1'b0, ST_INSERTED, 8'd0},
    '{ROW_OP,  OP_INSERT, 31'd5,          9'd0,   1'b1, ST_FULL,     8'd0},
    '{ROW_OP,  OP_INSERT, 31'd0,          9'd0,   1'b1, ST_PRESENT,  8'd0},
    '{ROW_OP,  OP_SEARCH, 31'd5,          9'd0,   1'b1, ST_MISSING,  8'd0},
    '{ROW_CFG, OP_INSERT, 31'd0,          9'd0,   1'b0, ST_INSERTED, 8'd0},
    '{ROW_OP,  OP_SEARCH, 31'd0,          9'd0,   1'b1, ST_FOUND,    8'd0},
    '{ROW_OP,  OP_INSERT, 31'd7,          9'd0,   1'b1, ST_FULL,     8'd0},
    '{ROW_CFG, OP_INSERT, 31'd0,          9'd2,   1'b0, ST_INSERTED, 8'd0},
    '{ROW_OP,  OP_INSERT, 31'd3,          9'd0,   1'b1, ST_FULL,     8'd0},
    '{ROW_OP,  OP_SEARCH, 31'd256,        9'd0,   1'b1, ST_FOUND,    8'd1},
    '{ROW_CFG, OP_INSERT, 31'd0,          9'd511, 1'b0, ST_INSERTED, 8'd0},
    '{ROW_OP,  OP_SEARCH, 31'h5555_5555,  9'd0,   1'b0, ST_INSERTED, 8'd0},
    '{ROW_OP,  OP_SEARCH, 31'd256,        9'd0,   1'b0, ST_INSERTED, 8'd0}
  };

  linear_probe_hash_set u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .opcode_i     (opcode_i),
    .key_value_i  (key_value_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .status_o     (status_o),
    .slot_index_o (slot_index_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  // Free-running clock.
  always begin
    #HALF_PERIOD clk_i = 1'b1;
    #HALF_PERIOD clk_i = 1'b0;
  end

  // The capacity register clamps zero to one and anything above the table depth to the depth.
  function automatic int unsigned effective_capacity(input logic [8:0] raw);
    if (raw == 9'd0) begin
      return 1;
    end
    if (raw > TABLE_DEPTH) begin
      return TABLE_DEPTH;
    end
    return int'(raw);
  endfunction

  // Walks the probe sequence on the shadow table and applies an insert when it lands on a hole.
  function automatic hash_result_t probe_and_update(input logic op, input logic [KEY_W-1:0] key);
    int unsigned  cap;
    int unsigned  idx;
    int unsigned  where;
    probe_end_e   outcome;
    hash_result_t res;
    cap     = effective_capacity(shadow_cap);
    idx     = key % cap;
    where   = 0;
    outcome = PROBE_WRAPPED;
    for (int unsigned n = 0; n < cap; n++) begin
      if (!shadow_used[idx]) begin
        outcome = PROBE_EMPTY;
        where   = idx;
        break;
      end
      if (shadow_key[idx] == key) begin
        outcome = PROBE_HIT;
        where   = idx;
        break;
      end
      idx = (idx + 1 == cap) ? 0 : idx + 1;
    end
    if (op == OP_INSERT) begin
      case (outcome)
        PROBE_EMPTY: begin
          shadow_key[where]  = key;
          shadow_used[where] = 1'b1;
          res.status = ST_INSERTED;
        end
        PROBE_HIT: begin
          res.status = ST_PRESENT;
        end
        default: begin
          res.status = ST_FULL;
          where      = 0;
        end
      endcase
    end else if (outcome == PROBE_HIT) begin
      res.status = ST_FOUND;
    end else begin
      res.status = ST_MISSING;
      where      = 0;
    end
    res.slot = 8'(where);
    return res;
  endfunction

  // Keys lean toward collisions and reuse so that probes walk and duplicates show up.
  function automatic logic [KEY_W-1:0] pick_key();
    int unsigned cap;
    int unsigned roll;
    cap  = effective_capacity(shadow_cap);
    roll = $urandom_range(0, 99);
    if (roll < 35 && recent_keys.size() != 0) begin
      return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
    end else if (roll < 60) begin
      return KEY_W'($urandom_range(0, 3 * cap));
    end else if (roll < 85) begin
      return KEY_W'(cap * $urandom_range(0, 5000) + $urandom_range(0, 3));
    end else if (roll < 88) begin
      return {KEY_W{1'b1}};
    end
    return KEY_W'($urandom);
  endfunction

  // Offers one operation beat, with burst and gap shaping, and records the expectation.
  task automatic send_op(input logic op, input logic [KEY_W-1:0] key,
                         input bit typed, input hash_result_t typed_result);
    hash_result_t predicted;
    @(negedge clk_i);
    if (burst_left == 0) begin
      in_valid_i = 1'b0;
      repeat ($urandom_range(1, 8)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
    end
    in_valid_i  = 1'b1;
    opcode_i    = op;
    key_value_i = key;
    burst_left--;
    do @(posedge clk_i); while (in_stall_o);
    predicted = probe_and_update(op, key);
    pending_results.push_back(typed ? typed_result : predicted);
    recent_keys.push_back(key);
    if (recent_keys.size() > RECENT_DEPTH) begin
      void'(recent_keys.pop_front());
    end
    ops_sent++;
  endtask

  // Writes the capacity once every outstanding result has come back.
  task automatic write_capacity(input logic [8:0] cap);
    @(negedge clk_i);
    in_valid_i = 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
    cfg_valid_i = 1'b1;
    cfg_data_i  = cap;
    do @(posedge clk_i); while (!cfg_ready_o);
    shadow_cap = cap;
    cfg_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  // Receiver: changing stall patterns, plus a long hold-off on request.
  initial begin : receiver
    stall_mode_e mode;
    int unsigned mode_left;
    mode      = STALL_NONE;
    mode_left = 0;
    forever begin
      @(negedge clk_i);
      if (hold_request) begin
        out_stall_i = 1'b1;
        repeat (HOLD_CYCLES - 1) @(negedge clk_i);
        hold_request = 1'b0;
      end else begin
        if (mode_left == 0) begin
          mode      = stall_mode_e'($urandom_range(0, 3));
          mode_left = $urandom_range(8, 60);
        end
        mode_left--;
        case (mode)
          STALL_NONE:  out_stall_i = 1'b0;
          STALL_LIGHT: out_stall_i = ($urandom_range(0, 3) == 0);
          STALL_HEAVY: out_stall_i = ($urandom_range(0, 9) < 7);
          default:     out_stall_i = ~out_stall_i;
        endcase
      end
    end
  end

  // Result checker: every accepted output beat is matched against the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_results.size() == 0) begin
        $error("output beat with no operation pending: status %0d slot %0d",
               status_o, slot_index_o);
        error_count++;
      end else begin
        head_result = pending_results.pop_front();
        if (status_o !== head_result.status) begin
          $error("status mismatch: expected %0d, actual %0d", head_result.status, status_o);
          error_count++;
        end
        if (slot_index_o !== head_result.slot) begin
          $error("slot_index mismatch: expected %0d, actual %0d",
                 head_result.slot, slot_index_o);
          error_count++;
        end
        if (head_result.status <= ST_MISSING) begin
          status_seen[head_result.status]++;
        end
      end
    end
  end

  // Watchdog.
  initial begin
    #25_000_000;
    $display("linear_probe_hash_set regression: fail");
    $finish;
  end

  // Main sequence: reset, directed table, then random phases across capacities.
  initial begin
    hash_result_t typed_result;
    foreach (shadow_used[i]) begin
      shadow_used[i] = 1'b0;
      shadow_key[i]  = '0;
    end
    foreach (status_seen[i]) begin
      status_seen[i] = 0;
    end
    repeat (RESET_CYCLES) @(negedge clk_i);
    rst_ni = 1'b1;

    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == ROW_CFG) begin
        write_capacity(directed_rows[i].cap);
      end else begin
        typed_result.status = directed_rows[i].status;
        typed_result.slot   = directed_rows[i].slot;
        send_op(directed_rows[i].op, directed_rows[i].key, directed_rows[i].typed,
                typed_result);
      end
    end

    typed_result.status = ST_INSERTED;
    typed_result.slot   = '0;
    for (int unsigned phase = 0; phase < NUM_CAPS; phase++) begin
      write_capacity(random_caps[phase]);
      // One phase backs up the output side for a long stretch while beats keep coming.
      if (phase == HOLD_PHASE) begin
        hold_request = 1'b1;
      end
      for (int unsigned n = 0; n < RANDOM_PER_CAP; n++) begin
        send_op(($urandom_range(0, 99) < 55) ? OP_INSERT : OP_SEARCH, pick_key(), 1'b0,
                typed_result);
      end
    end

    @(negedge clk_i);
    in_valid_i = 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Ran %0d operations over %0d capacity writes, including a long output hold-off.",
             ops_sent, cfg_writes);
    $display("Outcomes: %0d inserted, %0d duplicate, %0d full, %0d found, %0d missing.",
             status_seen[ST_INSERTED], status_seen[ST_PRESENT], status_seen[ST_FULL],
             status_seen[ST_FOUND], status_seen[ST_MISSING]);
    if (error_count == 0) begin
      $display("linear_probe_hash_set regression: pass");
    end else begin
      $display("linear_probe_hash_set regression: fail");
    end
    $finish;
  end

endmodule
